FILE: rtl/max_window_sum_locator_assert.svh
// Assertion macros used by the checker file.
`ifndef MAX_WINDOW_SUM_LOCATOR_ASSERT_SVH
`define MAX_WINDOW_SUM_LOCATOR_ASSERT_SVH

// Clocked property, switched off while reset is low.
`define MWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked through reset.
`define MWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/mws_pkg.sv
`default_nettype none

package mws_pkg;

    // Field widths of the input and result words
    localparam int SAMPLE_BITS   = 16;
    localparam int POSITION_BITS = 20;
    localparam int CFG_BITS      = 14;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_item;
    } t_in_word;

    typedef struct packed {
        logic [POSITION_BITS-1:0] best_start;
        logic                     too_long;
    } t_out_word;

endpackage

`default_nettype wire

FILE: rtl/mws_ring.sv
`default_nettype none

// Single-port sample ring with read-first behavior and a registered read.
module mws_ring #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Read the old entry and overwrite it in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_data      <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/max_window_sum_locator.sv
// A last word's result passes through the back-stage register, then the output register.
// Throughput: one sample word per cycle while not stalled; the ring is read and written
// at one address in the same cycle; sum, subtract and compare run one stage later.
// Input stall rises only while a last word waits behind an unaccepted result.
// Reset (synchronous, active low) clears all counters, sums and valids; the ring
// is not cleared, as an old entry is only used once the ring has filled in a sequence.
`default_nettype none

module max_window_sum_locator
    import mws_pkg::*;
#(
    parameter int WINDOW_MAX = 8192
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire t_in_word            i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output t_out_word                o_out_word,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [CFG_BITS-1:0] i_cfg_wr_data
);

    localparam int PTR_BITS = $clog2(WINDOW_MAX);
    localparam int LEN_BITS = $clog2(WINDOW_MAX + 1);
    localparam int SUM_BITS = SAMPLE_BITS + PTR_BITS;
    localparam int CMP_BITS = (LEN_BITS > CFG_BITS) ? LEN_BITS : CFG_BITS;
    localparam int IDX_BITS = ((POSITION_BITS > LEN_BITS) ? POSITION_BITS : LEN_BITS) + 1;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // Configuration
    logic [CFG_BITS-1:0] r_window_len;

    // Front stage: sequence control
    logic [PTR_BITS-1:0]      r_ring_ptr, n_ring_ptr;
    logic                     r_filled, n_filled;
    logic                     r_active, n_active;
    logic [LEN_BITS-1:0]      r_len_cur, n_len_cur;
    logic [POSITION_BITS-1:0] r_position, n_position;
    logic                     r_at_max, n_at_max;
    logic                     r_overflow, n_overflow;

    // Back stage: one word in flight
    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic                          r_s1_last;
    logic                          r_s1_was_filled;
    logic                          r_s1_first_fill;
    logic [POSITION_BITS-1:0]      r_s1_start;
    logic                          r_s1_ovf;

    // Back stage: sums
    logic signed [SUM_BITS-1:0] r_sum, n_sum;
    logic signed [SUM_BITS-1:0] r_best_sum, n_best_sum;
    logic [POSITION_BITS-1:0]   r_best_idx, n_best_idx;

    // Output register
    logic      r_out_valid, n_out_valid;
    t_out_word r_out_word, n_out_word;

    logic                     out_free;
    logic                     s1_hold;
    logic                     s1_fire;
    logic                     accept;
    logic [CMP_BITS-1:0]      cfg_ext;
    logic [LEN_BITS-1:0]      len_use;
    logic [LEN_BITS-1:0]      ptr_inc;
    logic                     wrap;
    logic                     ovf;
    logic [IDX_BITS-1:0]      pos_inc;
    logic [IDX_BITS-1:0]      len_x;
    logic [POSITION_BITS-1:0] s0_start;
    logic [SAMPLE_BITS-1:0]   ring_rd;
    logic signed [SUM_BITS-1:0] old_ext;
    logic signed [SUM_BITS-1:0] new_ext;
    logic signed [SUM_BITS-1:0] sum_new;

    // Handshake: hold the input only while a last word cannot retire
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_hold    = r_s1_valid && r_s1_last && !out_free;
    assign s1_fire    = r_s1_valid && !s1_hold;
    assign accept     = i_in_valid && !s1_hold;
    assign o_in_stall = s1_hold;

    // Clamp the configured length into 1..WINDOW_MAX; keep the latched length during a sequence
    always_comb begin
        cfg_ext = CMP_BITS'(r_window_len);
        priority if (r_active) begin
            len_use = r_len_cur;
        end else if (cfg_ext == '0) begin
            len_use = LEN_BITS'(1);
        end else if (cfg_ext > CMP_BITS'(WINDOW_MAX)) begin
            len_use = LEN_BITS'(WINDOW_MAX);
        end else begin
            len_use = LEN_BITS'(cfg_ext);
        end
    end

    // Ring pointer step, window start index and overflow tracking
    always_comb begin
        ptr_inc  = LEN_BITS'(r_ring_ptr) + LEN_BITS'(1);
        wrap     = (ptr_inc >= len_use);
        ovf      = r_overflow || r_at_max;
        pos_inc  = IDX_BITS'(r_position) + IDX_BITS'(1);
        len_x    = IDX_BITS'(len_use);
        s0_start = (pos_inc >= len_x) ? POSITION_BITS'(pos_inc - len_x) : '0;
    end

    // Front stage next state
    always_comb begin
        n_ring_ptr = r_ring_ptr;
        n_filled   = r_filled;
        n_active   = r_active;
        n_len_cur  = r_len_cur;
        n_position = r_position;
        n_at_max   = r_at_max;
        n_overflow = r_overflow;
        if (accept) begin
            n_len_cur = len_use;
            if (i_in_word.last_item) begin
                n_ring_ptr = '0;
                n_filled   = 1'b0;
                n_active   = 1'b0;
                n_position = '0;
                n_at_max   = 1'b0;
                n_overflow = 1'b0;
            end else begin
                n_ring_ptr = wrap ? '0 : PTR_BITS'(ptr_inc);
                n_filled   = r_filled || wrap;
                n_active   = 1'b1;
                n_overflow = ovf;
                if (r_position == POS_MAX) begin
                    n_at_max = 1'b1;
                end else begin
                    n_position = r_position + POSITION_BITS'(1);
                end
            end
        end
    end

    // Sample ring: fetch the oldest sample while storing the new one
    mws_ring #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (SAMPLE_BITS)
    ) u_ring (
        .i_clk     (i_clk),
        .i_en      (accept),
        .i_addr    (r_ring_ptr),
        .i_wr_data (i_in_word.sample),
        .o_rd_data (ring_rd)
    );

    // Slide the window sum, track the best window and load the result word on a last word
    always_comb begin
        old_ext = {{(SUM_BITS - SAMPLE_BITS){ring_rd[SAMPLE_BITS-1]}}, ring_rd};
        new_ext = {{(SUM_BITS - SAMPLE_BITS){r_s1_sample[SAMPLE_BITS-1]}}, r_s1_sample};
        sum_new = (r_s1_was_filled ? (r_sum - old_ext) : r_sum) + new_ext;

        n_sum       = r_sum;
        n_best_sum  = r_best_sum;
        n_best_idx  = r_best_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        if (s1_fire) begin
            n_sum = sum_new;
            if (r_s1_first_fill) begin
                n_best_sum = sum_new;
                n_best_idx = '0;
            end else if (r_s1_was_filled && (sum_new >= r_best_sum)) begin
                n_best_sum = sum_new;
                n_best_idx = r_s1_start;
            end
            if (r_s1_last) begin
                n_out_valid           = 1'b1;
                n_out_word.best_start = n_best_idx;
                n_out_word.too_long   = r_s1_ovf;
                n_sum                 = '0;
                n_best_sum            = '0;
                n_best_idx            = '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= CFG_BITS'(1);
            r_ring_ptr   <= '0;
            r_filled     <= 1'b0;
            r_active     <= 1'b0;
            r_len_cur    <= LEN_BITS'(1);
            r_position   <= '0;
            r_at_max     <= 1'b0;
            r_overflow   <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_sum        <= '0;
            r_best_sum   <= '0;
            r_best_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_window_len <= i_cfg_wr_data;
            end
            r_ring_ptr  <= n_ring_ptr;
            r_filled    <= n_filled;
            r_active    <= n_active;
            r_len_cur   <= n_len_cur;
            r_position  <= n_position;
            r_at_max    <= n_at_max;
            r_overflow  <= n_overflow;
            r_s1_valid  <= accept || s1_hold;
            r_sum       <= n_sum;
            r_best_sum  <= n_best_sum;
            r_best_idx  <= n_best_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: advance the back stage on accept, load the result word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample     <= i_in_word.sample;
            r_s1_last       <= i_in_word.last_item;
            r_s1_was_filled <= r_filled;
            r_s1_first_fill <= !r_filled && wrap;
            r_s1_start      <= s0_start;
            r_s1_ovf        <= ovf;
        end
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

FILE: rtl/mws_checker.sv
`default_nettype none

`include "max_window_sum_locator_assert.svh"

module mws_checker
    import mws_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     i_in_stall,
    input wire t_in_word i_in_word,
    input wire logic     i_out_valid,
    input wire logic     i_out_stall
);

    logic acc_last;

    assign acc_last = i_rst_n && i_in_valid && !i_in_stall && i_in_word.last_item;

    // Reset empties the output register
    `MWS_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !i_out_valid, "result word valid after reset")

    // A stalled result word stays offered
    `MWS_ASSERT(a_out_held, i_clk, i_rst_n, i_out_valid && i_out_stall |=> i_out_valid, "stalled result word dropped")

    // Input stall only comes from a full, stalled output
    `MWS_ASSERT(a_stall_cause, i_clk, i_rst_n, i_in_stall |-> i_out_valid && i_out_stall, "input stalled without a blocked result word")

    // An accepted last word, with no reset after it, leads to a valid result word
    `MWS_ASSERT(a_last_yields_out, i_clk, i_rst_n, (acc_last ##1 i_rst_n) |=> i_out_valid, "no result word after last sample word")

endmodule

bind max_window_sum_locator mws_checker u_mws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);

`default_nettype wire
